// ===== hdl/pfa_pkg.sv =====
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int DEF_MAX_COLORS   = 16;
    localparam int DEF_MAX_SEQUENCE = 16;
    localparam int RESULT_LIMIT     = 16;

    // Width of |target - current| * step, which is at most 31 * 255.
    localparam int DIV_W = 13;

    localparam logic [2:0] MODE_LOAD_COLOR = 3'd0;
    localparam logic [2:0] MODE_LOAD_SLOT  = 3'd1;
    localparam logic [2:0] MODE_START      = 3'd2;
    localparam logic [2:0] MODE_GRAY       = 3'd3;
    localparam logic [2:0] MODE_TICK       = 3'd4;

    localparam logic [2:0] REG_PALETTE_OFFSET  = 3'd0;
    localparam logic [2:0] REG_COLOR_COUNT     = 3'd1;
    localparam logic [2:0] REG_TOTAL_STEPS     = 3'd2;
    localparam logic [2:0] REG_USE_SEQUENCE    = 3'd3;
    localparam logic [2:0] REG_SEQUENCE_LENGTH = 3'd4;
    localparam logic [2:0] REG_SEQUENCE_DELAY  = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  entry_index;
        logic [14:0] target_color;
        logic [14:0] original_color;
        logic [3:0]  slot_position;
        logic [7:0]  slot_color_index;
    } t_in_beat;

    typedef struct packed {
        logic [8:0]  palette_address;
        logic [14:0] color;
        logic        last;
        logic        still_active;
    } t_out_beat;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [7:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEQ_READ,
        ST_SEQ_CHECK,
        ST_READ,
        ST_LOAD,
        ST_GRAY_SUM,
        ST_GRAY_DIV,
        ST_MUL,
        ST_DIV,
        ST_WRITE
    } t_state;

endpackage

// ===== hdl/pfa_in_if.sv =====
`timescale 1ns / 1ps

interface pfa_in_if;
    import pfa_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pfa_out_if.sv =====
`timescale 1ns / 1ps

interface pfa_out_if;
    import pfa_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/palette_fade_animator.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Handshake                  Beat
// i_in       in         i_in.valid / i_in.ready    one command (load, start, grey, tick)
// o_out      out        o_out.valid / o_out.ready  one palette colour write
// APB        in         psel, penable, pwrite      one register write or read
//
// Each colour written costs memory access plus, for a fade step, three channel
// divisions in the shared serial divider, taken one after another.
// Reset is synchronous and active low; it clears the control state and the
// registers, while the palette and sequence memories hold nothing until loaded.
// A stalled o_out holds the sequencer in its write state; a new command is
// taken whenever the sequencer is idle, even with a result still waiting.

module palette_fade_animator #(
    parameter int MAX_COLORS   = pfa_pkg::DEF_MAX_COLORS,
    parameter int MAX_SEQUENCE = pfa_pkg::DEF_MAX_SEQUENCE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfa_in_if.sink      i_in,
    pfa_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfa_pkg::*;

    localparam int CW = $clog2(MAX_COLORS);
    localparam int SW = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;
    localparam int USE_LIMIT = (MAX_COLORS < RESULT_LIMIT) ? MAX_COLORS : RESULT_LIMIT;
    localparam logic [4:0] USE_LIMIT_V = 5'(USE_LIMIT);

    // Configuration registers.
    logic [7:0] r_offset;
    logic [4:0] r_color_count;
    logic [7:0] r_total;
    logic       r_use_seq;
    logic [4:0] r_seq_len;
    logic [7:0] r_seq_delay;

    // Animation state.
    logic [7:0] r_step;
    logic [4:0] r_pos;
    logic [7:0] r_delay;
    logic       r_active;

    // Sequencer.
    t_state     r_state, n_state;
    logic [4:0] r_idx;
    logic [4:0] r_end;
    logic       r_gray;
    logic [7:0] r_k;
    logic       r_act_after;
    logic [4:0] r_slot_pos;
    logic [1:0] r_ch;
    logic [14:0] r_new;
    logic [11:0] r_sum;

    t_out_beat  r_out;
    logic       r_out_valid;

    // Each colour word holds {target, original, current}.
    logic [44:0] r_color_mem [MAX_COLORS];
    logic [44:0] r_color_rd;
    logic [7:0]  r_seq_mem [MAX_SEQUENCE];
    logic [7:0]  r_seq_rd;

    logic          w_cmem_we;
    logic [CW-1:0] w_cmem_waddr;
    logic [44:0]   w_cmem_wdata;
    logic          w_smem_we;

    logic       w_accept;
    logic       w_cfg_wr;
    logic [4:0] w_used;
    logic       w_out_free;
    logic       w_last;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // Per-channel operands of the current fade step.
    logic [14:0] w_cur, w_tgt, w_orig;
    logic [4:0]  w_from, w_to, w_mag, w_q;
    logic        w_neg;

    // Decisions taken as a command is accepted.
    logic       w_seq_wait;
    logic [7:0] w_step1;
    logic [4:0] w_pos1;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_used   = (r_color_count > USE_LIMIT_V) ? USE_LIMIT_V : r_color_count;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_last   = ((r_idx + 5'd1) == r_end);

    assign w_tgt  = r_color_rd[44:30];
    assign w_orig = r_color_rd[29:15];
    assign w_cur  = r_color_rd[14:0];

    assign w_step1    = r_step + 8'd1;
    assign w_pos1     = r_pos + 5'd1;
    assign w_seq_wait = (r_delay < r_seq_delay);

    always_comb begin
        unique case (paddr[4:2])
            REG_PALETTE_OFFSET:  prdata = {24'd0, r_offset};
            REG_COLOR_COUNT:     prdata = {27'd0, r_color_count};
            REG_TOTAL_STEPS:     prdata = {24'd0, r_total};
            REG_USE_SEQUENCE:    prdata = {31'd0, r_use_seq};
            REG_SEQUENCE_LENGTH: prdata = {27'd0, r_seq_len};
            REG_SEQUENCE_DELAY:  prdata = {24'd0, r_seq_delay};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset      <= 8'd0;
            r_color_count <= 5'd16;
            r_total       <= 8'd16;
            r_use_seq     <= 1'b0;
            r_seq_len     <= 5'd0;
            r_seq_delay   <= 8'd0;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_PALETTE_OFFSET:  r_offset      <= pwdata[7:0];
                REG_COLOR_COUNT:     r_color_count <= pwdata[4:0];
                REG_TOTAL_STEPS:     r_total       <= pwdata[7:0];
                REG_USE_SEQUENCE:    r_use_seq     <= pwdata[0];
                REG_SEQUENCE_LENGTH: r_seq_len     <= pwdata[4:0];
                REG_SEQUENCE_DELAY:  r_seq_delay   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Channel select for the fade arithmetic; red sits in the low five bits.
    always_comb begin
        case (r_ch)
            2'd0:    begin w_from = w_cur[4:0];   w_to = w_tgt[4:0];   end
            2'd1:    begin w_from = w_cur[9:5];   w_to = w_tgt[9:5];   end
            default: begin w_from = w_cur[14:10]; w_to = w_tgt[14:10]; end
        endcase
        w_neg = (w_to < w_from);
        w_mag = w_neg ? (w_from - w_to) : (w_to - w_from);
        w_q   = w_div_rsp.quotient[4:0];
    end

    pfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.data.mode == MODE_GRAY) begin
                        if (w_used != 5'd0) n_state = ST_READ;
                    end else if (i_in.data.mode == MODE_TICK && r_active) begin
                        if (r_use_seq) begin
                            if (!w_seq_wait && r_pos < r_seq_len
                                && 32'(r_pos) < MAX_SEQUENCE) begin
                                n_state = ST_SEQ_READ;
                            end
                        end else if (w_used > 5'd1) begin
                            n_state = ST_READ;
                        end
                    end
                end
            end
            ST_SEQ_READ:  n_state = ST_SEQ_CHECK;
            ST_SEQ_CHECK: n_state = ({3'd0, w_used} > r_seq_rd) ? ST_READ : ST_IDLE;
            ST_READ:      n_state = ST_LOAD;
            ST_LOAD: begin
                if (r_gray) begin
                    n_state = (r_idx == 5'd0) ? ST_WRITE : ST_GRAY_SUM;
                end else begin
                    n_state = (r_k >= r_total) ? ST_WRITE : ST_MUL;
                end
            end
            ST_GRAY_SUM:  n_state = ST_GRAY_DIV;
            ST_GRAY_DIV:  n_state = ST_WRITE;
            ST_MUL:       n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_rsp.done) n_state = (r_ch == 2'd2) ? ST_WRITE : ST_MUL;
            end
            ST_WRITE: begin
                if (w_out_free) n_state = w_last ? ST_IDLE : ST_READ;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory ports, divider start and input ready.
    always_comb begin
        i_in.ready         = (r_state == ST_IDLE);
        w_cmem_we          = 1'b0;
        w_cmem_waddr       = CW'(r_idx);
        w_cmem_wdata       = {w_tgt, w_orig, r_new};
        w_smem_we          = 1'b0;
        w_div_req.start    = (r_state == ST_MUL);
        w_div_req.dividend = DIV_W'(w_mag) * DIV_W'(r_k);
        w_div_req.divisor  = r_total;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in.data.mode == MODE_LOAD_COLOR
                    && 32'(i_in.data.entry_index) < MAX_COLORS) begin
                    w_cmem_we    = 1'b1;
                    w_cmem_waddr = CW'(i_in.data.entry_index);
                    w_cmem_wdata = {i_in.data.target_color, i_in.data.original_color,
                                    i_in.data.original_color};
                end
                w_smem_we = w_accept && i_in.data.mode == MODE_LOAD_SLOT
                            && 32'(i_in.data.slot_position) < MAX_SEQUENCE;
            end
            ST_WRITE: w_cmem_we = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_cmem_we) r_color_mem[w_cmem_waddr] <= w_cmem_wdata;
        r_color_rd <= r_color_mem[CW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (w_smem_we) r_seq_mem[SW'(i_in.data.slot_position)] <= i_in.data.slot_color_index;
        r_seq_rd <= r_seq_mem[SW'(r_slot_pos)];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 8'd0;
            r_pos       <= 5'd0;
            r_delay     <= 8'd0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_WRITE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                if (i_in.data.mode == MODE_START) begin
                    r_step   <= 8'd0;
                    r_pos    <= 5'd0;
                    r_delay  <= 8'd0;
                    r_active <= 1'b1;
                end else if (i_in.data.mode == MODE_GRAY) begin
                    r_step   <= 8'd0;
                    r_active <= 1'b1;
                end else if (i_in.data.mode == MODE_TICK && r_active) begin
                    if (!r_use_seq) begin
                        r_step <= w_step1;
                        if (w_step1 >= r_total) r_active <= 1'b0;
                    end else if (w_seq_wait) begin
                        r_delay <= r_delay + 8'd1;
                    end else begin
                        r_delay <= 8'd0;
                        if (w_step1 >= r_total) begin
                            r_step <= 8'd0;
                            r_pos  <= w_pos1;
                            if (w_pos1 >= r_seq_len) r_active <= 1'b0;
                        end else begin
                            r_step <= w_step1;
                        end
                    end
                end
            end
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_k        <= r_step;
                r_slot_pos <= r_pos;
                r_gray     <= (i_in.data.mode == MODE_GRAY);
                r_end      <= w_used;
                r_idx      <= (i_in.data.mode == MODE_GRAY) ? 5'd0 : 5'd1;
                if (i_in.data.mode == MODE_GRAY) begin
                    r_act_after <= 1'b1;
                end else if (!r_use_seq) begin
                    r_act_after <= !(w_step1 >= r_total);
                end else begin
                    r_act_after <= !(w_step1 >= r_total && w_pos1 >= r_seq_len);
                end
            end
            ST_SEQ_CHECK: begin
                r_idx <= r_seq_rd[4:0];
                r_end <= r_seq_rd[4:0] + 5'd1;
            end
            ST_LOAD: begin
                r_ch  <= 2'd0;
                r_new <= (!r_gray && r_k >= r_total) ? w_tgt : w_cur;
            end
            ST_GRAY_SUM: begin
                r_sum <= 12'(w_orig[4:0]) * 12'd30 + 12'(w_orig[9:5]) * 12'd59
                         + 12'(w_orig[14:10]) * 12'd11;
            end
            ST_GRAY_DIV: begin
                // Division by 100 as a multiply by 5243 / 2^19, exact for sums below 43699.
                r_new <= {3{5'((25'(r_sum) * 25'd5243) >> 19)}};
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    r_ch <= r_ch + 2'd1;
                    case (r_ch)
                        2'd0:    r_new[4:0]   <= w_neg ? (w_from - w_q) : (w_from + w_q);
                        2'd1:    r_new[9:5]   <= w_neg ? (w_from - w_q) : (w_from + w_q);
                        default: r_new[14:10] <= w_neg ? (w_from - w_q) : (w_from + w_q);
                    endcase
                end
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    r_idx                 <= r_idx + 5'd1;
                    r_out.palette_address <= {1'b0, r_offset} + {4'd0, r_idx};
                    r_out.color           <= r_new;
                    r_out.last            <= w_last;
                    r_out.still_active    <= r_act_after;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// ===== hdl/pfa_div.sv =====
`timescale 1ns / 1ps

module pfa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfa_pkg::t_div_req i_req,
    output pfa_pkg::t_div_rsp o_rsp
);
    import pfa_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [7:0]       r_div;

    logic [8:0] w_trial;
    logic       w_bit;
    logic [7:0] w_rem;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_bit   = (w_trial >= {1'b0, r_div});
        w_rem   = w_bit ? 8'(w_trial - {1'b0, r_div}) : w_trial[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_quo <= {r_quo[DIV_W-2:0], w_bit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== verif/palette_fade_animator_test.sv =====
`timescale 1ns / 1ps

// Testbench for the palette fade animator.
// A directed table is walked first, then random phases, each with its own
// register setting. Every accepted command is run through a predictor that
// keeps its own copy of the palettes, the sequence list and the fade state,
// and each colour write leaving the block is checked against the oldest
// prediction.

module palette_fade_animator_test;
    import pfa_pkg::*;

    localparam int NUM_REGS      = 6;
    localparam int IDLE_SETTLE   = 60;
    localparam int LONG_HOLD     = 3000;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 22;

    typedef struct {
        bit         is_cfg;
        logic [2:0] reg_idx;
        int         value;
        t_in_beat   beat;
        bit         chk;
        int         chk_k;
        logic [8:0]  exp_addr;
        logic [14:0] exp_color;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pfa_in_if  in_ch ();
    pfa_out_if out_ch ();

    palette_fade_animator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the block's state and registers.
    logic [14:0] target_pal [16];
    logic [14:0] original_pal [16];
    logic [14:0] current_pal [16];
    logic [7:0]  seq_list [16];
    logic [7:0]  fade_step;
    logic [4:0]  seq_pos;
    logic [7:0]  delay_cnt;
    logic        fading;
    int          reg_val [NUM_REGS];

    t_out_beat pending_writes [$];
    t_out_beat last_batch [16];

    int  mismatch_count = 0;
    int  writes_checked = 0;
    int  beats_sent = 0;
    int  idle_cycles = 0;
    bit  hold_req = 0;
    int  rx_style = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function automatic logic [4:0] fade_channel(input int from, input int to);
        int d;
        int q;
        d = (to - from) * int'(fade_step);
        q = d / reg_val[REG_TOTAL_STEPS];
        return 5'((from + q) & 31);
    endfunction

    function automatic logic [14:0] fade_colour(input logic [14:0] cur,
                                                input logic [14:0] tgt);
        if (int'(fade_step) >= reg_val[REG_TOTAL_STEPS])
            return tgt;
        return {fade_channel(cur[14:10], tgt[14:10]),
                fade_channel(cur[9:5], tgt[9:5]),
                fade_channel(cur[4:0], tgt[4:0])};
    endfunction

    function automatic logic [14:0] grey_of(input logic [14:0] c);
        int y;
        y = (int'(c[4:0]) * 30 + int'(c[9:5]) * 59 + int'(c[14:10]) * 11) / 100;
        return {5'(y), 5'(y), 5'(y)};
    endfunction

    // Works out the colour writes caused by one command, updates the shadow
    // state and queues them. Returns how many writes were produced.
    function automatic int predict_palette_writes(input t_in_beat b);
        int n;
        int k;
        int idx;
        n = (reg_val[REG_COLOR_COUNT] > 16) ? 16 : reg_val[REG_COLOR_COUNT];
        k = 0;
        case (b.mode)
            MODE_LOAD_COLOR: begin
                target_pal[b.entry_index]   = b.target_color;
                original_pal[b.entry_index] = b.original_color;
                current_pal[b.entry_index]  = b.original_color;
            end
            MODE_LOAD_SLOT: seq_list[b.slot_position] = b.slot_color_index;
            MODE_START: begin
                fade_step = 0;
                seq_pos   = 0;
                delay_cnt = 0;
                fading    = 1;
            end
            MODE_GRAY: begin
                for (int i = 1; i < n; i++)
                    current_pal[i] = grey_of(original_pal[i]);
                for (int i = 0; i < n; i++) begin
                    last_batch[k].palette_address = 9'(reg_val[REG_PALETTE_OFFSET] + i);
                    last_batch[k].color = current_pal[i];
                    k++;
                end
                fade_step = 0;
                fading    = 1;
            end
            MODE_TICK: begin
                if (!fading) begin
                    // An idle block ignores ticks.
                end else if (reg_val[REG_USE_SEQUENCE] != 0) begin
                    if (int'(delay_cnt) < reg_val[REG_SEQUENCE_DELAY]) begin
                        delay_cnt++;
                    end else begin
                        delay_cnt = 0;
                        if (int'(seq_pos) < reg_val[REG_SEQUENCE_LENGTH] && seq_pos < 16) begin
                            idx = seq_list[seq_pos[3:0]];
                            if (idx < n) begin
                                current_pal[idx] = fade_colour(current_pal[idx],
                                                               target_pal[idx]);
                                last_batch[k].palette_address =
                                    9'(reg_val[REG_PALETTE_OFFSET] + idx);
                                last_batch[k].color = current_pal[idx];
                                k++;
                            end
                        end
                        fade_step++;
                        if (int'(fade_step) >= reg_val[REG_TOTAL_STEPS]) begin
                            fade_step = 0;
                            seq_pos++;
                            if (int'(seq_pos) >= reg_val[REG_SEQUENCE_LENGTH])
                                fading = 0;
                        end
                    end
                end else begin
                    for (int i = 1; i < n; i++) begin
                        current_pal[i] = fade_colour(current_pal[i], target_pal[i]);
                        last_batch[k].palette_address = 9'(reg_val[REG_PALETTE_OFFSET] + i);
                        last_batch[k].color = current_pal[i];
                        k++;
                    end
                    fade_step++;
                    if (int'(fade_step) >= reg_val[REG_TOTAL_STEPS])
                        fading = 0;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < k; i++) begin
            last_batch[i].last = (i == k - 1);
            last_batch[i].still_active = fading;
            pending_writes.push_back(last_batch[i]);
        end
        return k;
    endfunction

    // Receiver: stall pattern chosen per phase, plus one long hold on request.
    initial begin
        int cyc;
        cyc = 0;
        out_ch.ready <= 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req) begin
                out_ch.ready <= 0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 0;
            end else begin
                case (rx_style)
                    0: out_ch.ready <= 1;
                    1: out_ch.ready <= ($urandom_range(1, 100) > 45);
                    default: out_ch.ready <= ((cyc % 8) < 3);
                endcase
            end
        end
    end

    // Checks each accepted colour write against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write addr %0d colour %h",
                                          out_ch.data.palette_address, out_ch.data.color));
            end else begin
                t_out_beat e;
                e = pending_writes.pop_front();
                writes_checked++;
                if (out_ch.data.palette_address !== e.palette_address)
                    report_mismatch($sformatf("address %0d, predicted %0d",
                                              out_ch.data.palette_address, e.palette_address));
                if (out_ch.data.color !== e.color)
                    report_mismatch($sformatf("colour %h, predicted %h at addr %0d",
                                              out_ch.data.color, e.color, e.palette_address));
                if (out_ch.data.last !== e.last)
                    report_mismatch($sformatf("last %b, predicted %b at addr %0d",
                                              out_ch.data.last, e.last, e.palette_address));
                if (out_ch.data.still_active !== e.still_active)
                    report_mismatch($sformatf("active %b, predicted %b at addr %0d",
                                              out_ch.data.still_active, e.still_active,
                                              e.palette_address));
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves anywhere.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Timeout with %0d writes outstanding", pending_writes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] r, input int v);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= 5'(r) << 2;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        reg_val[r] = v;
    endtask

    // Waits until every predicted write has come out and the block has had
    // time to finish a command that produces nothing.
    task automatic wait_drained();
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    int burst_left = 0;

    // Offers one beat, holds it until accepted, then predicts its writes.
    // The sender works in bursts with random gaps in between.
    task automatic send_command(input t_in_beat b, output int produced);
        in_ch.valid <= 1;
        in_ch.data  <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        produced = predict_palette_writes(b);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            int gap;
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                in_ch.valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic quiet_sender();
        in_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_in_beat make_beat(input logic [2:0] m, input int e, input int tgt,
                                           input int org, input int slot, input int sidx);
        t_in_beat b;
        b.mode = m;
        b.entry_index = 4'(e);
        b.target_color = 15'(tgt);
        b.original_color = 15'(org);
        b.slot_position = 4'(slot);
        b.slot_color_index = 8'(sidx);
        return b;
    endfunction

    function automatic t_plan_row plan_cfg(input logic [2:0] r, input int v);
        t_plan_row p;
        p = '{default: 0};
        p.is_cfg = 1;
        p.reg_idx = r;
        p.value = v;
        return p;
    endfunction

    function automatic t_plan_row plan_cmd(input t_in_beat b);
        t_plan_row p;
        p = '{default: 0};
        p.beat = b;
        return p;
    endfunction

    function automatic t_plan_row plan_chk(input t_in_beat b, input int k,
                                           input int addr, input int colour);
        t_plan_row p;
        p = plan_cmd(b);
        p.chk = 1;
        p.chk_k = k;
        p.exp_addr = 9'(addr);
        p.exp_color = 15'(colour);
        return p;
    endfunction

    // Random command mix: mostly ticks, with loads, restarts, grey passes and unused modes.
    function automatic t_in_beat random_command();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return make_beat(MODE_LOAD_COLOR, $urandom_range(0, 15), $urandom_range(0, 32767),
                             $urandom_range(0, 32767), $urandom_range(0, 15),
                             $urandom_range(0, 255));
        if (pick < 17)
            return make_beat(MODE_LOAD_SLOT, $urandom_range(0, 15), $urandom_range(0, 32767),
                             $urandom_range(0, 32767), $urandom_range(0, 15),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 15));
        if (pick < 24 || !fading)
            return make_beat(MODE_START, $urandom_range(0, 15), $urandom_range(0, 32767),
                             $urandom_range(0, 32767), $urandom_range(0, 15),
                             $urandom_range(0, 255));
        if (pick < 28)
            return make_beat(MODE_GRAY, 0, 0, 0, 0, 0);
        if (pick < 30)
            return make_beat(3'($urandom_range(5, 7)), $urandom_range(0, 15),
                             $urandom_range(0, 32767), $urandom_range(0, 32767),
                             $urandom_range(0, 15), $urandom_range(0, 255));
        return make_beat(MODE_TICK, $urandom_range(0, 15), $urandom_range(0, 32767),
                         $urandom_range(0, 32767), $urandom_range(0, 15),
                         $urandom_range(0, 255));
    endfunction

    function automatic int pick_extreme(input int lo, input int hi, input int typ_hi);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(lo, typ_hi);
    endfunction

    initial begin
        t_plan_row plan [$];
        int produced;
        int phase_count;

        in_ch.valid <= 0;
        in_ch.data  <= '0;
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 0;
        fade_step = 0;
        seq_pos   = 0;
        delay_cnt = 0;
        fading    = 0;
        reg_val = '{0, 16, 16, 0, 0, 0};
        for (int i = 0; i < 16; i++) begin
            target_pal[i] = 0;
            original_pal[i] = 0;
            current_pal[i] = 0;
            seq_list[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Every palette entry and list slot is filled before anything reads
        // them, since the memories hold nothing defined after reset.
        for (int i = 0; i < 16; i++) begin
            send_command(make_beat(MODE_LOAD_COLOR, i, $urandom_range(0, 32767),
                                   $urandom_range(0, 32767), 0, 0), produced);
            send_command(make_beat(MODE_LOAD_SLOT, 0, 0, 0, i, $urandom_range(0, 15)),
                         produced);
        end

        // Directed part. Entry 1 is white to white, entry 2 black to white.
        plan.push_back(plan_cmd(make_beat(MODE_LOAD_COLOR, 1, 15'h7FFF, 15'h7FFF, 0, 0)));
        plan.push_back(plan_cmd(make_beat(MODE_LOAD_COLOR, 2, 15'h7FFF, 15'h0000, 0, 0)));
        // A tick with the block never started is ignored.
        plan.push_back(plan_cmd(make_beat(MODE_TICK, 0, 0, 0, 0, 0)));
        // Unused modes do nothing, whatever the other fields hold.
        plan.push_back(plan_cmd(make_beat(3'd5, 15, 15'h7FFF, 15'h7FFF, 15, 255)));
        plan.push_back(plan_cmd(make_beat(3'd7, 0, 0, 0, 0, 0)));
        // Grey of white is white and grey of black is black.
        plan.push_back(plan_chk(make_beat(MODE_GRAY, 0, 0, 0, 0, 0), 1, 1, 15'h7FFF));
        plan.push_back(plan_cmd(make_beat(MODE_TICK, 0, 0, 0, 0, 0)));
        // With no steps at all, a tick puts every colour but entry 0 on its target.
        plan.push_back(plan_cfg(REG_TOTAL_STEPS, 0));
        plan.push_back(plan_cmd(make_beat(MODE_START, 0, 0, 0, 0, 0)));
        plan.push_back(plan_chk(make_beat(MODE_TICK, 0, 0, 0, 0, 0), 1, 2, 15'h7FFF));
        // The highest base address carries past eight bits.
        plan.push_back(plan_cfg(REG_PALETTE_OFFSET, 255));
        plan.push_back(plan_chk(make_beat(MODE_GRAY, 0, 0, 0, 0, 0), 2, 257, 15'h0000));
        // A count of one emits entry 0 only; a count of zero emits nothing.
        plan.push_back(plan_cfg(REG_COLOR_COUNT, 1));
        plan.push_back(plan_cmd(make_beat(MODE_GRAY, 0, 0, 0, 0, 0)));
        plan.push_back(plan_cfg(REG_COLOR_COUNT, 0));
        plan.push_back(plan_cmd(make_beat(MODE_GRAY, 0, 0, 0, 0, 0)));
        // Sequence mode: a delay of two idle ticks, a slot out of range that
        // is skipped, and the run ending once the list is used up.
        plan.push_back(plan_cfg(REG_COLOR_COUNT, 16));
        plan.push_back(plan_cfg(REG_TOTAL_STEPS, 2));
        plan.push_back(plan_cfg(REG_USE_SEQUENCE, 1));
        plan.push_back(plan_cfg(REG_SEQUENCE_LENGTH, 3));
        plan.push_back(plan_cfg(REG_SEQUENCE_DELAY, 2));
        plan.push_back(plan_cmd(make_beat(MODE_LOAD_SLOT, 0, 0, 0, 1, 255)));
        plan.push_back(plan_cmd(make_beat(MODE_START, 0, 0, 0, 0, 0)));
        for (int i = 0; i < 20; i++)
            plan.push_back(plan_cmd(make_beat(MODE_TICK, 0, 0, 0, 0, 0)));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                quiet_sender();
                wait_drained();
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                send_command(plan[i].beat, produced);
                if (plan[i].chk && (produced <= plan[i].chk_k ||
                        last_batch[plan[i].chk_k].palette_address != plan[i].exp_addr ||
                        last_batch[plan[i].chk_k].color != plan[i].exp_color))
                    report_mismatch($sformatf("directed row %0d: prediction disagrees", i));
            end
        end

        // Random phases, each with a fresh register setting taken while idle.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiet_sender();
            wait_drained();
            rx_style = ph % 3;
            write_reg(REG_PALETTE_OFFSET, pick_extreme(0, 255, 255));
            write_reg(REG_COLOR_COUNT, ($urandom_range(0, 2) == 0) ?
                      pick_extreme(0, 16, 16) : 16);
            write_reg(REG_TOTAL_STEPS, pick_extreme(0, 255, 6));
            write_reg(REG_USE_SEQUENCE, (ph == 2) ? 0 : $urandom_range(0, 1));
            write_reg(REG_SEQUENCE_LENGTH, pick_extreme(0, 16, 16));
            write_reg(REG_SEQUENCE_DELAY, ($urandom_range(0, 9) == 0) ? 255 :
                      $urandom_range(0, 3));
            send_command(make_beat(MODE_START, 0, 0, 0, 0, 0), produced);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                // Long receiver hold while ticks keep coming, so the block
                // backs up and stops taking commands.
                if (ph == 2 && phase_count == 5)
                    hold_req = 1;
                send_command(random_command(), produced);
                phase_count++;
            end
        end

        quiet_sender();
        wait_drained();
        $display("Sent %0d commands and checked %0d palette writes", beats_sent,
                 writes_checked);
        $display("Covered grey passes, all-colour and sequence fades and register extremes");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
